// ----- rtl/hem_pkg.sv -----
// Shared types and constants of the hash edge merge block.
`timescale 1ns / 1ps
`default_nettype none
package hem_pkg;

    localparam int VERTEX_BITS = 24;
    localparam int HASH_SIZE   = 1024;
    localparam int HASH_BITS   = $clog2(HASH_SIZE);
    localparam int HASH_PRIME  = 1049;
    localparam int MASK_W      = 10;
    localparam int EDGE_W      = 28;
    localparam int LOAD_W      = 32;
    localparam int DEG_W       = 11;
    localparam int DEG_MAX     = 2047;
    localparam int INDEX_W     = 1;
    localparam int CFG_W       = 10;

    typedef enum logic [INDEX_W-1:0] {
        REG_BASE = 1'b0,
        REG_MASK = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        KIND_NEW   = 2'd0,
        KIND_MERGE = 2'd1,
        KIND_SELF  = 2'd2,
        KIND_FULL  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [VERTEX_BITS-1:0] source_vertex;
        logic [VERTEX_BITS-1:0] end_vertex;
        logic [LOAD_W-1:0]      edge_load;
        logic                   last_of_vertex;
    } in_item_t;

    typedef struct packed {
        kind_t                  result_kind;
        logic [EDGE_W-1:0]      edge_index;
        logic [VERTEX_BITS-1:0] merged_end;
        logic [LOAD_W-1:0]      load_total;
        logic [DEG_W-1:0]       vertex_degree;
        logic [DEG_W-1:0]       max_degree;
        logic                   vertex_closed;
    } out_item_t;

    // classified item handed from the front to the probe engine
    typedef struct packed {
        in_item_t          item;
        logic              self_loop;
        logic [MASK_W-1:0] hash;
    } job_t;

    typedef struct packed {
        logic              base_wr;
        logic              base_in;
        logic [MASK_W-1:0] hash_mask;
    } cfg_t;

    typedef struct packed {
        logic                   valid;
        logic [VERTEX_BITS-1:0] owner;
        logic [VERTEX_BITS-1:0] end_v;
        logic [EDGE_W-1:0]      edge_idx;
        logic [LOAD_W-1:0]      load;
    } slot_t;

endpackage
`default_nettype wire

// ----- rtl/hem_front.sv -----
// Front end: self-loop check, end-vertex hash and a two-entry job queue.
`timescale 1ns / 1ps
`default_nettype none
module hem_front
    import hem_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cfg_t     cfg,
    input  wire logic     push,
    input  wire in_item_t edge_item,
    input  wire logic     hold,
    output logic          q_full,
    output logic          job_valid,
    output job_t          job,
    input  wire logic     job_take
);

    job_t        q_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        in_ok;
    logic        take_ok;
    job_t        job_in;
    logic [2*MASK_W-1:0] hprod;

    // only the low bits of the product survive the mask
    assign hprod = {{MASK_W{1'b0}}, edge_item.end_vertex[MASK_W-1:0]}
                 * (2*MASK_W)'(HASH_PRIME);

    always_comb
    begin
        job_in           = '0;
        job_in.item      = edge_item;
        job_in.self_loop = (edge_item.source_vertex == edge_item.end_vertex);
        job_in.hash      = hprod[MASK_W-1:0] & cfg.hash_mask;
    end

    assign q_full    = (count_reg == 2'd2);
    assign job_valid = (count_reg != 2'd0);
    assign job       = q_reg[rd_ptr_reg];
    assign in_ok     = push && !q_full && !hold;
    assign take_ok   = job_take && job_valid;

    always_comb
    begin
        wr_ptr_next = in_ok   ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take_ok ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(in_ok) - 2'(take_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ok)
        begin
            q_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/hem_back.sv -----
// Probe engine: slot table, linear probing, edge numbering and degree tracking.
`timescale 1ns / 1ps
`default_nettype none
module hem_back
    import hem_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic job_valid,
    input  wire job_t job,
    output logic      job_take,
    input  wire logic out_full,
    output logic      res_valid,
    output out_item_t res_item,
    output logic      clearing
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EVAL  = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    job_t                 job_reg;
    logic [HASH_BITS-1:0] slot_reg, slot_next;
    logic [MASK_W-1:0]    probe_reg, probe_next;
    logic [HASH_BITS-1:0] clr_reg, clr_next;
    logic [EDGE_W-1:0]    next_edge_reg, next_edge_next;
    logic [EDGE_W-1:0]    vfe_reg, vfe_next;
    logic [DEG_W-1:0]     peak_reg, peak_next;
    slot_t                mem [HASH_SIZE];
    slot_t                rd_reg;

    logic                 mem_we;
    logic [HASH_BITS-1:0] mem_waddr;
    slot_t                mem_wdata;

    logic                 finish;
    logic                 new_edge;
    in_item_t             cur;
    kind_t                kind;
    logic [EDGE_W-1:0]    eidx;
    logic [LOAD_W-1:0]    total;
    logic                 owned;
    logic [LOAD_W:0]      sum;
    logic [LOAD_W-1:0]    sum_sat;
    logic [EDGE_W-1:0]    ne_new;
    logic [EDGE_W-1:0]    edge_span;
    logic [DEG_W-1:0]     degree;
    logic [DEG_W-1:0]     peak_new;
    logic [MASK_W-1:0]    wrap_next;

    assign clearing = (state_reg == S_CLEAR);
    assign owned    = rd_reg.valid && (rd_reg.owner == job_reg.item.source_vertex);
    assign sum      = {1'b0, rd_reg.load} + {1'b0, job_reg.item.edge_load};
    assign sum_sat  = sum[LOAD_W] ? {LOAD_W{1'b1}} : sum[LOAD_W-1:0];
    assign wrap_next = (MASK_W'(slot_reg) + 1'b1) & cfg.hash_mask;

    // probe sequencing and table writes
    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        probe_next = probe_reg;
        clr_next   = clr_reg;
        job_take   = 1'b0;
        finish     = 1'b0;
        new_edge   = 1'b0;
        cur        = job_reg.item;
        kind       = KIND_FULL;
        eidx       = '0;
        total      = '0;
        mem_we     = 1'b0;
        mem_waddr  = slot_reg;
        mem_wdata  = rd_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we         = 1'b1;
                mem_waddr      = clr_reg;
                mem_wdata      = '0;
                clr_next       = clr_reg + 1'b1;
                if (clr_reg == HASH_BITS'(HASH_SIZE - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (job_valid && !out_full)
                begin
                    job_take = 1'b1;
                    cur      = job.item;
                    if (job.self_loop)
                    begin
                        finish = 1'b1;
                        kind   = KIND_SELF;
                    end
                    else
                    begin
                        slot_next  = job.hash[HASH_BITS-1:0];
                        probe_next = '0;
                        state_next = S_EVAL;
                    end
                end
            end
            S_EVAL:
            begin
                if (!owned)
                begin
                    finish             = 1'b1;
                    new_edge           = 1'b1;
                    kind               = KIND_NEW;
                    eidx               = next_edge_reg;
                    total              = job_reg.item.edge_load;
                    mem_we             = 1'b1;
                    mem_wdata.valid    = 1'b1;
                    mem_wdata.owner    = job_reg.item.source_vertex;
                    mem_wdata.end_v    = job_reg.item.end_vertex;
                    mem_wdata.edge_idx = next_edge_reg;
                    mem_wdata.load     = job_reg.item.edge_load;
                    state_next         = S_IDLE;
                end
                else if (rd_reg.end_v == job_reg.item.end_vertex)
                begin
                    finish         = 1'b1;
                    kind           = KIND_MERGE;
                    eidx           = rd_reg.edge_idx;
                    total          = sum_sat;
                    mem_we         = 1'b1;
                    mem_wdata.load = sum_sat;
                    state_next     = S_IDLE;
                end
                else if (probe_reg == cfg.hash_mask)
                begin
                    finish     = 1'b1;
                    kind       = KIND_FULL;
                    state_next = S_IDLE;
                end
                else
                begin
                    slot_next  = wrap_next[HASH_BITS-1:0];
                    probe_next = probe_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // edge numbering and vertex degree on close
    always_comb
    begin
        ne_new    = next_edge_reg + EDGE_W'(new_edge);
        edge_span = ne_new - vfe_reg;
        degree    = (edge_span > EDGE_W'(DEG_MAX)) ? DEG_W'(DEG_MAX)
                                                   : edge_span[DEG_W-1:0];
        peak_new  = (cur.last_of_vertex && (degree > peak_reg)) ? degree : peak_reg;

        next_edge_next = next_edge_reg;
        vfe_next       = vfe_reg;
        peak_next      = peak_reg;
        if (finish)
        begin
            next_edge_next = ne_new;
            peak_next      = peak_new;
            if (cur.last_of_vertex)
            begin
                vfe_next = ne_new;
            end
        end
        if (cfg.base_wr)
        begin
            next_edge_next = EDGE_W'(cfg.base_in);
            vfe_next       = EDGE_W'(cfg.base_in);
        end

        res_valid              = finish;
        res_item.result_kind   = kind;
        res_item.edge_index    = eidx;
        res_item.merged_end    = cur.end_vertex;
        res_item.load_total    = total;
        res_item.vertex_degree = cur.last_of_vertex ? degree : '0;
        res_item.max_degree    = peak_new;
        res_item.vertex_closed = cur.last_of_vertex;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            slot_reg      <= '0;
            probe_reg     <= '0;
            clr_reg       <= '0;
            next_edge_reg <= '0;
            vfe_reg       <= '0;
            peak_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            probe_reg     <= probe_next;
            clr_reg       <= clr_next;
            next_edge_reg <= next_edge_next;
            vfe_reg       <= vfe_next;
            peak_reg      <= peak_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            job_reg <= job;
        end
    end

    // slot table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= mem[slot_next];
    end

endmodule
`default_nettype wire

// ----- rtl/hem_outq.sv -----
// Two-entry result queue in front of the result ports.
`timescale 1ns / 1ps
`default_nettype none
module hem_outq
    import hem_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      res_valid,
    input  wire out_item_t res_item,
    output logic           out_full,
    output logic           empty,
    input  wire logic      pop,
    output out_item_t      result_item
);

    out_item_t  q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       wr_ok;
    logic       rd_ok;

    assign out_full    = (count_reg == 2'd2);
    assign empty       = (count_reg == 2'd0);
    assign result_item = q_reg[rd_ptr_reg];
    assign wr_ok       = res_valid && !out_full;
    assign rd_ok       = pop && !empty;
    assign count_next  = count_reg + 2'(wr_ok) - 2'(rd_ok);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_ok)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (rd_ok)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            q_reg[wr_ptr_reg] <= res_item;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/hash_edge_merge.sv -----
// Top level: duplicate coarse-edge merge with a linearly probed slot table.
// Path: the front job queue, then the probe engine (idle, then an evaluate state
// for each probed slot; a self loop finishes in idle), then the result queue.
// The engine takes a new edge only after the last one has finished; each
// collision adds one more probe (up to hash_mask+1 probes).
// Reset: a clearing pass over all 1024 table slots holds full high.
`timescale 1ns / 1ps
`default_nettype none
module hash_edge_merge
    import hem_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire in_item_t           edge_item,
    output logic                    empty,
    input  wire logic               pop,
    output out_item_t               result_item,
    input  wire logic               cfg_we,
    input  wire logic [INDEX_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]   cfg_wdata
);

    // configuration: only the mask is held; a base write reloads the edge counters
    logic [MASK_W-1:0] hash_mask_reg, hash_mask_next;
    cfg_t              cfg;

    // front / back / result-queue handshakes
    logic      q_full;
    logic      job_valid;
    job_t      job;
    logic      job_take;
    logic      out_full;
    logic      res_valid;
    out_item_t res_item;
    logic      clearing;

    always_comb
    begin
        hash_mask_next = hash_mask_reg;
        if (cfg_we && (cfg_addr == REG_MASK))
        begin
            hash_mask_next = cfg_wdata[MASK_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_mask_reg <= {MASK_W{1'b1}};
        end
        else
        begin
            hash_mask_reg <= hash_mask_next;
        end
    end

    assign cfg.base_wr   = cfg_we && (cfg_addr == REG_BASE);
    assign cfg.base_in   = cfg_wdata[0];
    assign cfg.hash_mask = hash_mask_reg;

    // no item is taken while the table is being cleared
    assign full = q_full || clearing;

    hem_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .push      (push),
        .edge_item (edge_item),
        .hold      (clearing),
        .q_full    (q_full),
        .job_valid (job_valid),
        .job       (job),
        .job_take  (job_take)
    );

    // one item in flight; it starts only with room in the result queue
    hem_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job_valid (job_valid),
        .job       (job),
        .job_take  (job_take),
        .out_full  (out_full),
        .res_valid (res_valid),
        .res_item  (res_item),
        .clearing  (clearing)
    );

    hem_outq u_outq (
        .clk         (clk),
        .rst_n       (rst_n),
        .res_valid   (res_valid),
        .res_item    (res_item),
        .out_full    (out_full),
        .empty       (empty),
        .pop         (pop),
        .result_item (result_item)
    );

    // a finished item never meets a full result queue
    assert property (@(posedge clk) disable iff (!rst_n) res_valid |-> !out_full)
        else $error("result produced with result queue full");

    // nothing leaves the engine during the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n) clearing |-> !res_valid && !job_take)
        else $error("item handled during table clear");

    // dropped self loops and full-table results carry no edge
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result_item.result_kind == KIND_SELF ||
                    result_item.result_kind == KIND_FULL))
        |-> (result_item.edge_index == '0 && result_item.load_total == '0))
        else $error("dropped item carries edge data");

    // degree is reported only on close and never exceeds the running peak
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result_item.vertex_closed ||
                    result_item.vertex_degree == '0) &&
                   (result_item.vertex_degree <= result_item.max_degree))
        else $error("vertex degree inconsistent");

endmodule
`default_nettype wire

// ----- sim/hem_merge_monitor.sv -----
// Monitor for the hash edge merge block: predicts every result and compares it.
`timescale 1ns / 1ps
module hem_merge_monitor
    import hem_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                full,
    input  in_item_t            edge_item,
    input  logic                empty,
    input  logic                pop,
    input  out_item_t           result_item,
    input  logic                cfg_we,
    input  logic [INDEX_W-1:0]  cfg_addr,
    input  logic [CFG_W-1:0]    cfg_wdata,
    output int                  mismatches,
    output int                  outstanding
);

    // shadow slot table
    bit                     slot_used  [HASH_SIZE];
    logic [VERTEX_BITS-1:0] slot_owner [HASH_SIZE];
    logic [VERTEX_BITS-1:0] slot_end   [HASH_SIZE];
    logic [EDGE_W-1:0]      slot_edge  [HASH_SIZE];
    logic [LOAD_W-1:0]      slot_load  [HASH_SIZE];

    logic                   base_bit;
    logic [MASK_W-1:0]      mask_reg;
    logic [EDGE_W-1:0]      next_edge;
    logic [EDGE_W-1:0]      first_edge;
    logic [DEG_W-1:0]       degree_peak;

    out_item_t              awaited_results[$];
    out_item_t              want;
    int                     i;

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    // probe the shadow table for one edge and return the result it should give
    function automatic out_item_t merge_edge(input in_item_t it);
        out_item_t         r;
        logic [31:0]       prod;
        logic [MASK_W-1:0] h;
        logic [HASH_BITS-1:0] s;
        logic [LOAD_W:0]   sum;
        logic [EDGE_W-1:0] span;
        logic [DEG_W-1:0]  deg;
        bit                done;
        int                n;
        r = '0;
        r.result_kind   = KIND_FULL;
        r.merged_end    = it.end_vertex;
        r.vertex_closed = it.last_of_vertex;
        if (it.source_vertex == it.end_vertex)
        begin
            r.result_kind = KIND_SELF;
        end
        else
        begin
            prod = it.end_vertex * HASH_PRIME;
            h    = prod[MASK_W-1:0] & mask_reg;
            done = 1'b0;
            for (n = 0; n <= int'(mask_reg) && !done; n++)
            begin
                s = h;
                if (!slot_used[s] || slot_owner[s] != it.source_vertex)
                begin
                    slot_used[s]  = 1'b1;
                    slot_owner[s] = it.source_vertex;
                    slot_end[s]   = it.end_vertex;
                    slot_edge[s]  = next_edge;
                    slot_load[s]  = it.edge_load;
                    r.result_kind = KIND_NEW;
                    r.edge_index  = next_edge;
                    r.load_total  = it.edge_load;
                    next_edge     = next_edge + 1'b1;
                    done          = 1'b1;
                end
                else if (slot_end[s] == it.end_vertex)
                begin
                    sum = {1'b0, slot_load[s]} + {1'b0, it.edge_load};
                    if (sum[LOAD_W])
                        sum[LOAD_W-1:0] = '1;
                    slot_load[s]  = sum[LOAD_W-1:0];
                    r.result_kind = KIND_MERGE;
                    r.edge_index  = slot_edge[s];
                    r.load_total  = sum[LOAD_W-1:0];
                    done          = 1'b1;
                end
                else
                begin
                    h = (h + 1'b1) & mask_reg;
                end
            end
        end
        if (it.last_of_vertex)
        begin
            span = next_edge - first_edge;
            deg  = (span > DEG_MAX) ? DEG_W'(DEG_MAX) : span[DEG_W-1:0];
            if (deg > degree_peak)
                degree_peak = deg;
            first_edge      = next_edge;
            r.vertex_degree = deg;
        end
        r.max_degree = degree_peak;
        return r;
    endfunction

    task automatic flag(input string field, input logic [31:0] exp_v, input logic [31:0] got_v);
        $display("%0t ns: %s expected %0h actual %0h", $time, field, exp_v, got_v);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (i = 0; i < HASH_SIZE; i++)
            begin
                slot_used[i]  = 1'b0;
                slot_owner[i] = '1;
            end
            base_bit    = 1'b0;
            mask_reg    = '1;
            next_edge   = '0;
            first_edge  = '0;
            degree_peak = '0;
            awaited_results.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == REG_BASE)
                begin
                    base_bit   = cfg_wdata[0];
                    next_edge  = EDGE_W'(base_bit);
                    first_edge = EDGE_W'(base_bit);
                end
                else
                begin
                    mask_reg = cfg_wdata[MASK_W-1:0];
                end
            end
            // results leave before this edge's item can have produced one
            if (pop && !empty)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none actual %0h",
                             $time, result_item);
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (result_item.result_kind !== want.result_kind)
                        flag("result_kind", want.result_kind, result_item.result_kind);
                    if (result_item.edge_index !== want.edge_index)
                        flag("edge_index", want.edge_index, result_item.edge_index);
                    if (result_item.merged_end !== want.merged_end)
                        flag("merged_end", want.merged_end, result_item.merged_end);
                    if (result_item.load_total !== want.load_total)
                        flag("load_total", want.load_total, result_item.load_total);
                    if (result_item.vertex_degree !== want.vertex_degree)
                        flag("vertex_degree", want.vertex_degree, result_item.vertex_degree);
                    if (result_item.max_degree !== want.max_degree)
                        flag("max_degree", want.max_degree, result_item.max_degree);
                    if (result_item.vertex_closed !== want.vertex_closed)
                        flag("vertex_closed", want.vertex_closed, result_item.vertex_closed);
                end
            end
            if (push && !full)
                awaited_results.push_back(merge_edge(edge_item));
            outstanding = awaited_results.size();
        end
    end

endmodule

// ----- sim/hash_edge_merge_test.sv -----
// Top of the hash edge merge testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module hash_edge_merge_test;
    import hem_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;  // far beyond the slowest legal run
    localparam int HOLD_CYCLES  = 300;      // long receiver hold-off
    localparam int DRAIN_CYCLES = 40;       // quiet tail after the last result
    localparam int GROUP_ITEMS  = 100;      // random items per configuration

    logic                clk = 1'b0;
    logic                rst_n;
    logic                push;
    logic                full;
    in_item_t            edge_item;
    logic                empty;
    logic                pop;
    out_item_t           result_item;
    logic                cfg_we;
    logic [INDEX_W-1:0]  cfg_addr;
    logic [CFG_W-1:0]    cfg_wdata;

    int                  mismatches;
    int                  outstanding;
    int                  cycle_count   = 0;

    // idle percentages of the two sides, changed per phase
    int                  send_idle_pct = 36;
    int                  recv_idle_pct = 50;

    // hold-off requests from the stimulus, served by the receiver process
    int                  holds_asked   = 0;
    int                  holds_served  = 0;

    // current source vertex of the random stream
    logic [VERTEX_BITS-1:0] src_cursor = '0;

    hash_edge_merge dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .edge_item   (edge_item),
        .empty       (empty),
        .pop         (pop),
        .result_item (result_item),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata)
    );

    hem_merge_monitor monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .edge_item   (edge_item),
        .empty       (empty),
        .pop         (pop),
        .result_item (result_item),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run-away guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: pops at random, or sits out a long hold-off when one is asked
    // for, so the block backs up and raises full while items keep coming.
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_served < holds_asked)
            begin
                holds_served++;
                pop <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
            begin
                pop <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // vertex ids stop at all-ones minus one; all-ones is the "no owner" stamp
    function automatic logic [VERTEX_BITS-1:0] vtx(input logic [31:0] v);
        return (v[VERTEX_BITS-1:0] == '1) ? '0 : v[VERTEX_BITS-1:0];
    endfunction

    function automatic in_item_t make_edge(input logic [VERTEX_BITS-1:0] s,
                                           input logic [VERTEX_BITS-1:0] e,
                                           input logic [LOAD_W-1:0] l,
                                           input logic c);
        in_item_t it;
        it.source_vertex  = s;
        it.end_vertex     = e;
        it.edge_load      = l;
        it.last_of_vertex = c;
        return it;
    endfunction

    // Offer one item and wait for the edge that takes it. push is left high
    // so back-to-back items go out without a bubble.
    task automatic offer(input in_item_t it);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        push      <= 1'b1;
        edge_item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // stop sending and wait until every result is back
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Random stream: mostly runs of edges for one source (ends drawn from a
    // small pool so duplicates merge, some ends one table size apart so they
    // share a probe chain, a few self loops), plus stray items and runs that
    // never close their vertex.
    task automatic random_group(input int count);
        int sent;
        int k;
        int pool;
        int j;
        bit close;
        logic [VERTEX_BITS-1:0] end_base;
        logic [VERTEX_BITS-1:0] e;
        logic [LOAD_W-1:0]      load;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                offer(make_edge(vtx($urandom), vtx($urandom), $urandom,
                                1'($urandom_range(0, 1))));
                sent++;
            end
            else
            begin
                case ($urandom_range(0, 7))
                    0: src_cursor = vtx($urandom);
                    1: ;  // same source again: revisit its stamped slots
                    default: src_cursor = vtx(src_cursor + $urandom_range(1, 3));
                endcase
                end_base = vtx($urandom);
                pool     = $urandom_range(1, 12);
                k        = ($urandom_range(0, 15) == 0) ? $urandom_range(12, 40)
                                                        : $urandom_range(1, 8);
                close    = ($urandom_range(0, 9) != 0);
                for (j = 0; j < k; j++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        e = src_cursor;
                    else if ($urandom_range(0, 3) == 0)
                        e = vtx(end_base + $urandom_range(0, pool - 1) * HASH_SIZE);
                    else
                        e = vtx(end_base + $urandom_range(0, pool - 1));
                    // some loads near the top so sums saturate
                    load = ($urandom_range(0, 5) == 0) ? (32'hFFFF_FF00 | $urandom_range(0, 255))
                                                       : $urandom;
                    offer(make_edge(src_cursor, e, load, close && (j == k - 1)));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        int g;
        logic [CFG_W-1:0] group_mask;
        rst_n     = 1'b0;
        push      = 1'b0;
        edge_item = '0;
        cfg_we    = 1'b0;
        cfg_addr  = REG_BASE;
        cfg_wdata = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // the table clearing pass after reset holds full high
        @(posedge clk);
        while (full)
            @(posedge clk);

        // ---- directed: numbering from 1, full table ----
        write_reg(REG_BASE, 1);
        write_reg(REG_MASK, 1023);
        offer(make_edge(0, 0, 0, 1'b0));                         // self loop
        offer(make_edge(0, 16777214, 32'hFFFF_FFFF, 1'b0));      // largest end, largest load
        offer(make_edge(0, 16777214, 5, 1'b0));                  // merge, load saturates
        offer(make_edge(0, 1, 0, 1'b0));
        offer(make_edge(0, 1, 7, 1'b1));                         // merge and close
        offer(make_edge(16777214, 16777214, 32'hFFFF_FFFF, 1'b1)); // self loop closes, no edges
        // ends one table size apart hash alike: linear probe chain
        offer(make_edge(5, 100, 1, 1'b0));
        offer(make_edge(5, 1124, 2, 1'b0));
        offer(make_edge(5, 2148, 3, 1'b0));
        offer(make_edge(5, 1124, 10, 1'b1));                     // merge one probe in
        offer(make_edge(5, 2148, 4, 1'b1));                      // source comes back
        offer(make_edge(7, 100, 9, 1'b1));                       // steals slot stamped by 5
        settle();

        // ---- directed: one-slot table, numbering restarts from 0 ----
        write_reg(REG_BASE, 0);
        write_reg(REG_MASK, 0);
        offer(make_edge(9, 10, 1, 1'b0));
        offer(make_edge(9, 11, 1, 1'b0));                        // table full
        offer(make_edge(9, 10, 2, 1'b0));
        offer(make_edge(10, 11, 3, 1'b1));                       // new owner takes the slot
        settle();

        // ---- directed: four slots, fifth distinct end overflows ----
        write_reg(REG_MASK, 3);
        offer(make_edge(20, 1, 1, 1'b0));
        offer(make_edge(20, 2, 2, 1'b0));
        offer(make_edge(20, 3, 3, 1'b0));
        offer(make_edge(20, 4, 4, 1'b0));
        offer(make_edge(20, 5, 5, 1'b1));
        offer(make_edge(20, 3, 32'hFFFF_FFFF, 1'b1));
        settle();

        // ---- random groups, each under its own settings ----
        // groups 0-1: sender idles 36%, receiver 50%; 2-3 swapped; 4-5 no idling
        for (g = 0; g < 6; g++)
        begin
            case (g)
                0: group_mask = 1023;
                1: group_mask = 15;
                2: group_mask = 3;
                3: group_mask = 1000;                            // not one less than a power of two
                4: group_mask = 0;
                default: group_mask = CFG_W'($urandom_range(0, 1023));
            endcase
            if (g == 2)
            begin
                send_idle_pct = 50;
                recv_idle_pct = 36;
            end
            else if (g == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(REG_BASE, CFG_W'($urandom_range(0, 1)));
            write_reg(REG_MASK, group_mask);
            // receiver backs off while the sender keeps pushing
            if (g == 1 || g == 5)
                holds_asked++;
            random_group(GROUP_ITEMS);
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
